[hw/rtl/onp_pkg.sv]
package onp_pkg;

    // quotient width of every divide in the datapath
    localparam int QUO_W = 32;

    localparam logic [QUO_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_M11 = 3'd0,
        REG_M22 = 3'd1,
        REG_M31 = 3'd2,
        REG_M32 = 3'd3,
        REG_M33 = 3'd4,
        REG_M43 = 3'd5
    } cfg_reg_t;

    // sign / saturate an unsigned quotient magnitude
    function automatic logic [QUO_W-1:0] sat_quot(
        input logic [QUO_W-1:0] mag,
        input logic             ovf,
        input logic             num_neg,
        input logic             den_neg,
        input logic             den_zero
    );
        logic [QUO_W-1:0] r;
        if (den_zero)
        begin
            r = num_neg ? S32_MIN : S32_MAX;
        end
        else if (num_neg ^ den_neg)
        begin
            r = (ovf || (mag > S32_MIN)) ? S32_MIN : (~mag + 32'd1);
        end
        else
        begin
            r = (ovf || mag[QUO_W-1]) ? S32_MAX : mag;
        end
        return r;
    endfunction

endpackage

[hw/rtl/onp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// First stage checks for quotient overflow past 32 bits.
module onp_div #(
    parameter int NW = 49,
    parameter int DW = 32
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [NW-1:0]              num,
    input  logic [DW-1:0]              den,
    output logic [onp_pkg::QUO_W-1:0]  quo,
    output logic                       ovf
);

    localparam int QW = onp_pkg::QUO_W;
    localparam int MW = NW + DW;

    logic [DW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] lo_reg  [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic          ovf_reg [0:QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(num >> QW);
            lo_reg[0]  <= num[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= ((MW'(num) >> QW) >= MW'(den));
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;

        assign trial = {rem_reg[k-1], lo_reg[k-1][QW-1]};
        assign ge    = (trial >= {1'b0, den_reg[k-1]});
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= {quo_reg[k-1][QW-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    lo_reg[k]  <= {lo_reg[k-1][QW-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

[hw/rtl/oblique_near_plane_projection.sv]
// Oblique near-plane projection column.
// Slave stream: one camera-space clip plane (a, b, c, d) per request, signed
// fixed point with FRAC_BITS fraction bits. Master stream: the four values that
// replace the projection's third column, plus a divide-error flag in tuser.
// Config port: cfg_we/cfg_index/cfg_data write m11, m22, m31, m32, m33, m43
// (indices 0..5, others ignored). Write only while no request is in flight.
// Pipeline: input reg, 33-stage divider for the corner point, multiply, dot
// sum, 33-stage divider for the column, output reg. Throughput: one plane per
// cycle when not stalled; the two pipelined bit-per-stage dividers set the
// depth, not the rate.
// Reset: all valid bits clear, registers return to identity-like defaults
// (m11 = m22 = m33 = m43 = 1.0, m31 = m32 = 0).
// Stall: when the output holds a result and m_tready is low, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
module oblique_near_plane_projection #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // slave
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // plane_a, plane_b, plane_c, plane_d
    // master
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // col_x, col_y, col_z, col_w
    output logic         m_tuser,   // divide_error
    // config
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int QW      = onp_pkg::QUO_W;
    localparam int NW      = 33 + FRAC_BITS;  // |numerator| << shift
    localparam int DOTW    = 66 - FRAC_BITS;  // four floored products
    localparam int DIV_LAT = QW + 1;

    typedef struct packed {
        logic             valid;
        logic [3:0][31:0] p;
        logic [2:0]       nneg;
        logic [2:0]       dneg;
        logic [2:0]       dz;
    } side1_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] nneg;
        logic       dneg;
        logic       dz;
        logic       err;
    } side2_t;

    // ---------------- configuration ----------------
    logic signed [31:0] m11_reg, m22_reg, m31_reg, m32_reg, m33_reg, m43_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m11_reg <= 32'sd1 <<< FRAC_BITS;
            m22_reg <= 32'sd1 <<< FRAC_BITS;
            m31_reg <= '0;
            m32_reg <= '0;
            m33_reg <= 32'sd1 <<< FRAC_BITS;
            m43_reg <= 32'sd1 <<< FRAC_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                onp_pkg::REG_M11: m11_reg <= cfg_data;
                onp_pkg::REG_M22: m22_reg <= cfg_data;
                onp_pkg::REG_M31: m31_reg <= cfg_data;
                onp_pkg::REG_M32: m32_reg <= cfg_data;
                onp_pkg::REG_M33: m33_reg <= cfg_data;
                onp_pkg::REG_M43: m43_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: freeze only when the output holds an untaken result
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // ---------------- stage A: input register ----------------
    logic             a_valid_reg;
    logic [3:0][31:0] a_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            a_p_reg <= s_tdata;
    end

    // corner point numerators: (sgn + offset) << F, and divisors
    logic signed [32:0] one33;
    logic signed [32:0] sgn_a, sgn_b;
    logic signed [32:0] n_sum [3];
    logic [32:0]        n_mag [3];
    logic [NW-1:0]      q_num [3];
    logic [31:0]        q_den [3];
    logic signed [31:0] q_den_s [3];
    logic [2:0]         q_nneg, q_dneg, q_dz;

    assign one33 = 33'sd1 <<< FRAC_BITS;

    always_comb
    begin
        sgn_a = (a_p_reg[0] == '0) ? '0 : (a_p_reg[0][31] ? -one33 : one33);
        sgn_b = (a_p_reg[1] == '0) ? '0 : (a_p_reg[1][31] ? -one33 : one33);
        n_sum[0]   = sgn_a + 33'(m31_reg);
        n_sum[1]   = sgn_b + 33'(m32_reg);
        n_sum[2]   = one33 + 33'(m33_reg);
        q_den_s[0] = m11_reg;
        q_den_s[1] = m22_reg;
        q_den_s[2] = m43_reg;
        for (int i = 0; i < 3; i++)
        begin
            q_nneg[i] = n_sum[i][32];
            n_mag[i]  = n_sum[i][32] ? 33'(-n_sum[i]) : 33'(n_sum[i]);
            q_num[i]  = {n_mag[i], {FRAC_BITS{1'b0}}};
            q_dneg[i] = q_den_s[i][31];
            q_den[i]  = q_den_s[i][31] ? 32'(-q_den_s[i]) : 32'(q_den_s[i]);
            q_dz[i]   = (q_den_s[i] == '0);
        end
    end

    // ---------------- corner point dividers ----------------
    logic [QW-1:0] q_quo [3];
    logic          q_ovf [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_qdiv
        onp_div #(.NW(NW), .DW(32)) u_div (
            .clk (clk),
            .en  (en),
            .num (q_num[i]),
            .den (q_den[i]),
            .quo (q_quo[i]),
            .ovf (q_ovf[i])
        );
    end

    side1_t side1_reg [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
                side1_reg[k] <= '0;
        end
        else if (en)
        begin
            side1_reg[0] <= '{valid: a_valid_reg, p: a_p_reg, nneg: q_nneg,
                              dneg: q_dneg, dz: q_dz};
            for (int k = 1; k < DIV_LAT; k++)
                side1_reg[k] <= side1_reg[k-1];
        end
    end

    // ---------------- stage M: products ----------------
    side1_t             s1;
    logic signed [31:0] q_val [3];
    logic signed [31:0] p0_s, p1_s, p3_s;

    assign s1 = side1_reg[DIV_LAT-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            q_val[i] = onp_pkg::sat_quot(q_quo[i], q_ovf[i], s1.nneg[i],
                                         s1.dneg[i], s1.dz[i]);
    end

    assign p0_s = s1.p[0];
    assign p1_s = s1.p[1];
    assign p3_s = s1.p[3];

    logic               mp_valid_reg;
    logic               mp_err_reg;
    logic [3:0][31:0]   mp_p_reg;
    logic signed [63:0] prod0_reg, prod1_reg, prod3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mp_valid_reg <= 1'b0;
        else if (en)
            mp_valid_reg <= s1.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_p_reg   <= s1.p;
            mp_err_reg <= |s1.dz;
            prod0_reg  <= p0_s * q_val[0];
            prod1_reg  <= p1_s * q_val[1];
            prod3_reg  <= p3_s * q_val[2];
        end
    end

    // ---------------- stage S: dot sum ----------------
    // q.z is exactly 1.0, so its floored product is plane_c itself
    logic signed [31:0]   p2_s;
    logic signed [DOTW-1:0] dot_next;

    assign p2_s     = mp_p_reg[2];
    assign dot_next = DOTW'(prod0_reg >>> FRAC_BITS) + DOTW'(prod1_reg >>> FRAC_BITS)
                    + DOTW'(p2_s) + DOTW'(prod3_reg >>> FRAC_BITS);

    logic                   sm_valid_reg;
    logic                   sm_err_reg;
    logic [3:0][31:0]       sm_p_reg;
    logic signed [DOTW-1:0] dot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_valid_reg <= 1'b0;
        else if (en)
            sm_valid_reg <= mp_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_p_reg   <= mp_p_reg;
            sm_err_reg <= mp_err_reg;
            dot_reg    <= dot_next;
        end
    end

    // column numerators p << (F+1), divisor |dot|
    logic [DOTW-1:0] dot_mag;
    logic [NW-1:0]   c_num [4];
    logic [3:0]      c_nneg;
    logic [31:0]     p_mag [4];

    assign dot_mag = dot_reg[DOTW-1] ? DOTW'(-dot_reg) : DOTW'(dot_reg);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            c_nneg[i] = sm_p_reg[i][31];
            p_mag[i]  = sm_p_reg[i][31] ? (~sm_p_reg[i] + 32'd1) : sm_p_reg[i];
            c_num[i]  = {p_mag[i], {(FRAC_BITS + 1){1'b0}}};
        end
    end

    // ---------------- column dividers ----------------
    logic [QW-1:0] c_quo [4];
    logic          c_ovf [4];

    for (genvar i = 0; i < 4; i++)
    begin : g_cdiv
        onp_div #(.NW(NW), .DW(DOTW)) u_div (
            .clk (clk),
            .en  (en),
            .num (c_num[i]),
            .den (dot_mag),
            .quo (c_quo[i]),
            .ovf (c_ovf[i])
        );
    end

    side2_t side2_reg [0:DIV_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
                side2_reg[k] <= '0;
        end
        else if (en)
        begin
            side2_reg[0] <= '{valid: sm_valid_reg, nneg: c_nneg,
                              dneg: dot_reg[DOTW-1], dz: (dot_reg == '0),
                              err: sm_err_reg};
            for (int k = 1; k < DIV_LAT; k++)
                side2_reg[k] <= side2_reg[k-1];
        end
    end

    // ---------------- output register ----------------
    side2_t           s2;
    logic [3:0][31:0] col_next;

    assign s2 = side2_reg[DIV_LAT-1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            col_next[i] = onp_pkg::sat_quot(c_quo[i], c_ovf[i], s2.nneg[i],
                                            s2.dneg, s2.dz);
    end

    logic [127:0] out_data_reg;
    logic         out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s2.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= col_next;
            out_err_reg  <= s2.err | s2.dz;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    // ---------------- assertions ----------------
    // zero x scale always sets m_tuser (user must keep config static in flight)
    a_m11_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m11_reg == '0)) |-> m_tuser)
        else $error("zero m11 without divide_error");

    a_m43_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m43_reg == '0)) |-> m_tuser)
        else $error("zero m43 without divide_error");

    // a frozen pipeline keeps the stage A, M and S valid bits in place
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(a_valid_reg) && $stable(mp_valid_reg) && $stable(sm_valid_reg)))
        else $error("pipeline moved while stalled");

endmodule
